/* hdl/atch_pkg.sv */
`default_nettype none
package atch_pkg;

	// Sequencer states of the heading engine
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_OFS,
		ST_DIFF,
		ST_ROLL_GO,
		ST_ROLL_WAIT,
		ST_PITCH_GO,
		ST_PITCH_WAIT,
		ST_MUL,
		ST_HEAD_GO,
		ST_HEAD_WAIT,
		ST_EMIT
	} atch_state_t;

	// Command to the shared CORDIC unit
	typedef struct packed {
		logic start;
		logic vec;
	} cord_ctl_t;

	// CORDIC gain 0.60725293 in Q30
	localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam int MUL_LAST = 9;
	localparam int HEAD_LAST = 7;

	// atan(2^-i) in 32-bit turns
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0: r = 32'h20000000;
			5'd1: r = 32'h12E4051E;
			5'd2: r = 32'h09FB385B;
			5'd3: r = 32'h051111D4;
			5'd4: r = 32'h028B0D43;
			5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E;
			5'd7: r = 32'h00517C55;
			5'd8: r = 32'h0028BE53;
			5'd9: r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* hdl/atch_cordic.sv */
`default_nettype none
module atch_cordic #(
	parameter int W = 54,
	parameter int STEPS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire atch_pkg::cord_ctl_t ctl,
	input wire logic signed [W-1:0] x0,
	input wire logic signed [W-1:0] y0,
	input wire logic [31:0] z0,
	output logic done,
	output logic signed [W-1:0] x,
	output logic signed [W-1:0] y,
	output logic [31:0] z
);
	import atch_pkg::*;

	localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic busy_q, done_q, vec_q;
	logic [IW-1:0] cnt_q;
	logic signed [W-1:0] x_q, y_q, dx, dy;
	logic [31:0] z_q, ang;
	logic p;

	// One micro-rotation per cycle
	always_comb begin
		dx = y_q >>> cnt_q;
		dy = x_q >>> cnt_q;
		ang = atan_turn(5'(cnt_q));
		p = vec_q ? y_q[W-1] : ~z_q[31];
	end

	// Step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			vec_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				vec_q <= ctl.vec;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == IW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Load or rotate the vector
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
		end else if (busy_q) begin
			if (p) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - ang;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + ang;
			end
		end
	end

	assign done = done_q;
	assign x = x_q;
	assign y = y_q;
	assign z = z_q;

endmodule
`default_nettype wire

/* hdl/autocal_tilt_compass_heading.sv */
// Tilt-compensated compass heading with running hard-iron calibration.
// Sample channel: sample_valid / sample_stall carry mag_x/y/z, roll_angle and
// pitch_angle. A request is taken when sample_valid is high and sample_stall
// low; sample_stall stays high while a sample is being worked on.
// Result channel: result_valid / result_stall carry the three current offsets
// and eight headings for the axis sign and swap combinations.
// One shared CORDIC unit runs ten times per sample, one micro-rotation a cycle,
// and one 32x32 multiplier is used for ten products. One sample is in work at a
// time: no new sample is taken until the last one's result is handed on.
// The finished result sits in an output register; the block takes the next
// sample while it waits. If the receiver stalls past the next sample's work,
// the sequencer holds its finished result until the register frees up.
// Reset clears the per-axis minimum to the most positive value and the
// maximum to the most negative value, so the first sample sets both; the
// first heading after reset is zero.
`default_nettype none
module autocal_tilt_compass_heading #(
	parameter int MAG_BITS = 16,
	parameter int ANGLE_BITS = 16,
	parameter int CORDIC_STEPS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic sample_valid,
	output logic sample_stall,
	input wire logic signed [MAG_BITS-1:0] mag_x,
	input wire logic signed [MAG_BITS-1:0] mag_y,
	input wire logic signed [MAG_BITS-1:0] mag_z,
	input wire logic signed [ANGLE_BITS-1:0] roll_angle,
	input wire logic signed [ANGLE_BITS-1:0] pitch_angle,
	output logic result_valid,
	input wire logic result_stall,
	output logic signed [MAG_BITS-1:0] offset_x,
	output logic signed [MAG_BITS-1:0] offset_y,
	output logic signed [MAG_BITS-1:0] offset_z,
	output logic [ANGLE_BITS-1:0] heading_px_py,
	output logic [ANGLE_BITS-1:0] heading_px_ny,
	output logic [ANGLE_BITS-1:0] heading_nx_py,
	output logic [ANGLE_BITS-1:0] heading_nx_ny,
	output logic [ANGLE_BITS-1:0] heading_py_px,
	output logic [ANGLE_BITS-1:0] heading_py_nx,
	output logic [ANGLE_BITS-1:0] heading_ny_px,
	output logic [ANGLE_BITS-1:0] heading_ny_nx
);
	import atch_pkg::*;

	localparam int MB = MAG_BITS;
	localparam int AB = ANGLE_BITS;
	localparam int DW = MAG_BITS + 2;
	localparam int CW = MAG_BITS + 38;

	atch_state_t state_q, state_d;
	cord_ctl_t cctl;

	logic signed [MB-1:0] raw_q [3];
	logic signed [MB-1:0] low_q [3];
	logic signed [MB-1:0] high_q [3];
	logic signed [MB-1:0] off_q [3];
	logic signed [MB-1:0] off_out_q [3];
	logic signed [DW-1:0] m_q [3];
	logic [AB-1:0] roll_q, pitch_q;
	logic signed [31:0] sr_q, cr_q, sp_q, cp_q;
	logic signed [63:0] prod_q [10];
	logic [AB-1:0] head_q [8];
	logic [AB-1:0] head_out_q [8];
	logic [3:0] mi_q;
	logic [2:0] k_q;
	logic neg_q, zero_q, rvalid_q;

	logic signed [CW-1:0] cx0, cy0, cx, cy, cxn, cyn;
	logic [31:0] cz0, cz, t, zr;
	logic [AB-1:0] ang_sel;
	logic fold;
	logic signed [31:0] opa, opb, srcp;
	logic signed [63:0] hx, hy, pa_cp, pa_sp, pb_cr;
	logic slot_free;
	logic cdone;

	// Tilt angle fold into +-90 degrees
	always_comb begin
		ang_sel = (state_q == ST_PITCH_GO) ? pitch_q : roll_q;
		t = {ang_sel, {(32-AB){1'b0}}};
		fold = (t[31:30] == 2'b01) || (t[31:30] == 2'b10);
	end

	// Corrected vector for combination k: swap = k[2], negate a = k[1], negate b = k[0]
	always_comb begin
		pa_cp = k_q[2] ? prod_q[5] : prod_q[4];
		pa_sp = k_q[2] ? prod_q[7] : prod_q[6];
		pb_cr = k_q[2] ? prod_q[8] : prod_q[9];
		hx = (k_q[1] ? -pa_cp : pa_cp) + prod_q[2];
		hy = (k_q[1] ? -pa_sp : pa_sp) + (k_q[0] ? -pb_cr : pb_cr) - prod_q[3];
	end

	// CORDIC start operands
	always_comb begin
		if (state_q == ST_HEAD_GO) begin
			cx0 = hx[63] ? -hx[CW-1:0] : hx[CW-1:0];
			cy0 = hx[63] ? -hy[CW-1:0] : hy[CW-1:0];
			cz0 = hx[63] ? HALF_TURN : 32'd0;
		end else begin
			cx0 = CW'(CORDIC_GAIN_Q30);
			cy0 = '0;
			cz0 = fold ? t + HALF_TURN : t;
		end
	end

	atch_cordic #(.W(CW), .STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(cctl),
		.x0(cx0),
		.y0(cy0),
		.z0(cz0),
		.done(cdone),
		.x(cx),
		.y(cy),
		.z(cz)
	);

	// Undo the fold and round the heading
	always_comb begin
		cxn = neg_q ? -cx : cx;
		cyn = neg_q ? -cy : cy;
		zr = cz + (32'd1 << (31 - AB));
	end

	// Multiplier operand select
	always_comb begin
		srcp = prod_q[1][61:30];
		unique case (mi_q)
			4'd0: begin opa = sr_q; opb = sp_q; end
			4'd1: begin opa = sr_q; opb = cp_q; end
			4'd2: begin opa = 32'(m_q[2]); opb = sp_q; end
			4'd3: begin opa = 32'(m_q[2]); opb = srcp; end
			4'd4: begin opa = 32'(m_q[0]); opb = cp_q; end
			4'd5: begin opa = 32'(m_q[1]); opb = cp_q; end
			4'd6: begin opa = 32'(m_q[0]); opb = prod_q[0][61:30]; end
			4'd7: begin opa = 32'(m_q[1]); opb = prod_q[0][61:30]; end
			4'd8: begin opa = 32'(m_q[0]); opb = cr_q; end
			4'd9: begin opa = 32'(m_q[1]); opb = cr_q; end
			default: begin opa = '0; opb = '0; end
		endcase
	end

	assign slot_free = !rvalid_q || !result_stall;

	// Next state and CORDIC commands
	always_comb begin
		state_d = state_q;
		cctl = '0;
		unique case (state_q)
			ST_IDLE: if (sample_valid) state_d = ST_OFS;
			ST_OFS: state_d = ST_DIFF;
			ST_DIFF: state_d = ST_ROLL_GO;
			ST_ROLL_GO: begin
				cctl.start = 1'b1;
				state_d = ST_ROLL_WAIT;
			end
			ST_ROLL_WAIT: if (cdone) state_d = ST_PITCH_GO;
			ST_PITCH_GO: begin
				cctl.start = 1'b1;
				state_d = ST_PITCH_WAIT;
			end
			ST_PITCH_WAIT: if (cdone) state_d = ST_MUL;
			ST_MUL: if (mi_q == 4'(MUL_LAST)) state_d = ST_HEAD_GO;
			ST_HEAD_GO: begin
				cctl.start = 1'b1;
				cctl.vec = 1'b1;
				state_d = ST_HEAD_WAIT;
			end
			ST_HEAD_WAIT: begin
				if (cdone) state_d = (k_q == 3'(HEAD_LAST)) ? ST_EMIT : ST_HEAD_GO;
			end
			ST_EMIT: if (slot_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// State, counters, result valid flag and calibration extremes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mi_q <= '0;
			k_q <= '0;
			rvalid_q <= 1'b0;
			for (int a = 0; a < 3; a++) begin
				low_q[a] <= {1'b0, {(MB-1){1'b1}}};
				high_q[a] <= {1'b1, {(MB-1){1'b0}}};
			end
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && sample_valid) begin
				if (mag_x < low_q[0]) low_q[0] <= mag_x;
				if (mag_x > high_q[0]) high_q[0] <= mag_x;
				if (mag_y < low_q[1]) low_q[1] <= mag_y;
				if (mag_y > high_q[1]) high_q[1] <= mag_y;
				if (mag_z < low_q[2]) low_q[2] <= mag_z;
				if (mag_z > high_q[2]) high_q[2] <= mag_z;
			end
			if (state_q == ST_PITCH_WAIT) mi_q <= '0;
			else if (state_q == ST_MUL) mi_q <= mi_q + 1'b1;
			if (state_q == ST_MUL) k_q <= '0;
			else if (state_q == ST_HEAD_WAIT && cdone) k_q <= k_q + 1'b1;
			// hold result until taken
			if (state_q == ST_EMIT && slot_free) rvalid_q <= 1'b1;
			else if (!result_stall) rvalid_q <= 1'b0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && sample_valid) begin
			raw_q[0] <= mag_x;
			raw_q[1] <= mag_y;
			raw_q[2] <= mag_z;
			roll_q <= roll_angle;
			pitch_q <= pitch_angle;
		end
		if (state_q == ST_OFS) begin
			for (int a = 0; a < 3; a++) begin
				off_q[a] <= MB'((($signed({low_q[a][MB-1], low_q[a]}))
					+ $signed({high_q[a][MB-1], high_q[a]})) >>> 1);
			end
		end
		if (state_q == ST_DIFF) begin
			for (int a = 0; a < 3; a++) begin
				m_q[a] <= DW'(raw_q[a]) - DW'(off_q[a]);
			end
		end
		if (state_q == ST_ROLL_GO || state_q == ST_PITCH_GO) neg_q <= fold;
		if (state_q == ST_ROLL_WAIT && cdone) begin
			sr_q <= cyn[31:0];
			cr_q <= cxn[31:0];
		end
		if (state_q == ST_PITCH_WAIT && cdone) begin
			sp_q <= cyn[31:0];
			cp_q <= cxn[31:0];
		end
		if (state_q == ST_MUL) prod_q[mi_q] <= opa * opb;
		if (state_q == ST_HEAD_GO) begin
			neg_q <= 1'b0;
			zero_q <= (hx == 64'sd0) && (hy == 64'sd0);
		end
		if (state_q == ST_HEAD_WAIT && cdone) head_q[k_q] <= zero_q ? '0 : zr[31 -: AB];
		if (state_q == ST_EMIT && slot_free) begin
			off_out_q <= off_q;
			head_out_q <= head_q;
		end
	end

	assign sample_stall = (state_q != ST_IDLE);
	assign result_valid = rvalid_q;
	assign offset_x = off_out_q[0];
	assign offset_y = off_out_q[1];
	assign offset_z = off_out_q[2];
	assign heading_px_py = head_out_q[0];
	assign heading_px_ny = head_out_q[1];
	assign heading_nx_py = head_out_q[2];
	assign heading_nx_ny = head_out_q[3];
	assign heading_py_px = head_out_q[4];
	assign heading_py_nx = head_out_q[5];
	assign heading_ny_px = head_out_q[6];
	assign heading_ny_nx = head_out_q[7];

endmodule
`default_nettype wire
